// ----- hdl/tmlc_pkg.sv -----
// ---------------------------------------------------------------------------
// tmlc_pkg
// shared types and register codes for the truncated mean layer charge block
// ---------------------------------------------------------------------------
package tmlc_pkg;

  localparam int unsigned SumW  = 24;
  localparam logic [23:0] SumMax = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_FRACTION  = 2'd1,
    CFG_SCALE     = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] pad_charge;
    logic        layer_end;
    logic        event_end;
  } in_t;

  typedef struct packed {
    logic [23:0] mean_charge;
    logic [7:0]  layers_hit;
    logic [7:0]  layers_kept;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SUM_INIT,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic pad_load;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic sum_start;
    logic sum_rd;
    logic sum_acc;
    logic div_step;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic close_ins;
    logic event_end;
    logic pos_zero;
    logic rd_gt;
    logic k_zero;
    logic sum_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/tmlc_ctrl.sv -----
// ---------------------------------------------------------------------------
// tmlc_ctrl
// sequencer for pad intake, sorted insertion, summing, divide and scale
// ---------------------------------------------------------------------------
module tmlc_ctrl import tmlc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   evt_q, evt_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      evt_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      evt_q   <= evt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    evt_d   = evt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          evt_d = sts_i.event_end;
          if (sts_i.close_ins) state_d = ST_INS_RD;
          else if (sts_i.event_end) state_d = ST_SUM_INIT;
        end
      end
      ST_INS_RD: begin
        if (sts_i.pos_zero) state_d = evt_q ? ST_SUM_INIT : ST_IDLE;
        else state_d = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (sts_i.rd_gt) state_d = ST_INS_RD;
        else state_d = evt_q ? ST_SUM_INIT : ST_IDLE;
      end
      ST_SUM_INIT: state_d = sts_i.k_zero ? ST_MUL : ST_SUM_RD;
      ST_SUM_RD:   state_d = ST_SUM_ACC;
      ST_SUM_ACC:  state_d = sts_i.sum_last ? ST_DIV : ST_SUM_RD;
      ST_DIV:      if (sts_i.div_last) state_d = ST_MUL;
      ST_MUL:      state_d = ST_OUT;
      ST_OUT:      if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:     cmd_o.pad_load = accept;
      ST_INS_RD: begin
        cmd_o.ins_rd    = !sts_i.pos_zero;
        cmd_o.ins_place = sts_i.pos_zero;
      end
      ST_INS_CMP: begin
        cmd_o.ins_shift = sts_i.rd_gt;
        cmd_o.ins_place = !sts_i.rd_gt;
      end
      ST_SUM_INIT: cmd_o.sum_start = 1'b1;
      ST_SUM_RD:   cmd_o.sum_rd    = 1'b1;
      ST_SUM_ACC:  cmd_o.sum_acc   = 1'b1;
      ST_DIV:      cmd_o.div_step  = 1'b1;
      ST_MUL:      cmd_o.mul       = 1'b1;
      ST_OUT:      cmd_o.out_load  = sts_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/tmlc_dp.sv -----
// ---------------------------------------------------------------------------
// tmlc_dp
// layer accumulator, sorted sum store, adder, serial divider and scaler
// ---------------------------------------------------------------------------
module tmlc_dp import tmlc_pkg::*; #(
  parameter int unsigned MAX_LAYERS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_t         in_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  localparam int unsigned CW = $clog2(MAX_LAYERS + 1);
  localparam int unsigned AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned TW = SumW + CW;
  localparam int unsigned DW = $clog2(TW + 1);

  logic [15:0]     thr_q, scale_q;
  logic [8:0]      frac_q;
  logic [SumW-1:0] sum_q, ins_q, rd_q, new_sum;
  logic [SumW:0]   add_s;
  logic [CW-1:0]   cnt_q, pos_q, k_q, k_c;
  logic [CW+8:0]   kprod;
  logic [8:0]      frac_c;
  logic [TW-1:0]   acc_q;
  logic [CW:0]     rem_q, rem_sh;
  logic [DW-1:0]   div_cnt_q;
  logic [39:0]     prod_q;
  logic [SumW-1:0] mem [MAX_LAYERS];
  logic [AW-1:0]   rd_addr;
  logic            out_valid_q;
  out_t            out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 16'd1;
      frac_q  <= 9'd179;
      scale_q <= 16'd54613;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: thr_q   <= cfg_data_i;
        CFG_FRACTION:  frac_q  <= cfg_data_i[8:0];
        CFG_SCALE:     scale_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign add_s   = {1'b0, sum_q} + {9'd0, in_data_i.pad_charge};
  assign new_sum = (in_data_i.pad_charge >= thr_q) ?
                   (add_s[SumW] ? SumMax : add_s[SumW-1:0]) : sum_q;

  assign frac_c = (frac_q > 9'd256) ? 9'd256 : frac_q;
  assign kprod  = (CW+9)'(frac_c) * (CW+9)'(cnt_q);
  assign k_c    = kprod[CW+7:8];

  assign rem_sh  = {rem_q[CW-1:0], acc_q[TW-1]};
  assign rd_addr = cmd_i.ins_rd ? AW'(pos_q - CW'(1)) : AW'(pos_q);

  assign sts_o.close_ins = (in_data_i.layer_end || in_data_i.event_end) &&
                           (new_sum != '0) && (32'(cnt_q) < 32'(MAX_LAYERS));
  assign sts_o.event_end = in_data_i.event_end;
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.rd_gt     = (rd_q > ins_q);
  assign sts_o.k_zero    = (k_c == '0);
  assign sts_o.sum_last  = (32'(pos_q) + 32'd1 == 32'(k_q));
  assign sts_o.div_last  = (div_cnt_q == DW'(TW - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // sorted store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_shift) mem[AW'(pos_q)] <= rd_q;
    else if (cmd_i.ins_place) mem[AW'(pos_q)] <= ins_q;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.pad_load)
        sum_q <= (in_data_i.layer_end || in_data_i.event_end) ? '0 : new_sum;
      if (cmd_i.ins_place) cnt_q <= cnt_q + CW'(1);
      else if (cmd_i.out_load) cnt_q <= '0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.pad_load) begin
      ins_q <= new_sum;
      pos_q <= cnt_q;
    end
    if (cmd_i.ins_shift) pos_q <= pos_q - CW'(1);
    if (cmd_i.sum_start) begin
      k_q   <= k_c;
      pos_q <= '0;
      acc_q <= '0;
    end
    if (cmd_i.sum_acc) begin
      acc_q     <= acc_q + TW'(rd_q);
      pos_q     <= pos_q + CW'(1);
      rem_q     <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DW'(1);
      if (rem_sh >= (CW+1)'(k_q)) begin
        rem_q <= rem_sh - (CW+1)'(k_q);
        acc_q <= {acc_q[TW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        acc_q <= {acc_q[TW-2:0], 1'b0};
      end
    end
    if (cmd_i.mul) prod_q <= 40'(acc_q[SumW-1:0]) * 40'(scale_q);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.mean_charge <= prod_q[39:16];
      out_q.layers_hit  <= (32'(cnt_q) > 32'd255) ? 8'hFF : 8'(cnt_q);
      out_q.layers_kept <= (32'(k_q) > 32'd255) ? 8'hFF : 8'(k_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(MAX_LAYERS))
    else $error("layer count beyond store depth");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result not presented");
  a_kept_le_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.layers_kept <= out_q.layers_hit))
    else $error("kept layers exceed hit layers");
`endif

endmodule

// ----- hdl/truncated_mean_layer_charge.sv -----
// ---------------------------------------------------------------------------
// truncated_mean_layer_charge
// truncated mean of per-layer pad charge sums over one event
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid / stall   | in_t  (pad_charge, layer_end, event_end)
//  out     | output    | out_valid / stall  | out_t (mean_charge, layers_hit, layers_kept)
//  cfg     | input     | cfg_valid / ready  | cfg_index, cfg_data
//
//  a pad that does not close a nonzero layer only updates the running layer sum
//  a closing layer adds an insertion into the sorted store: each larger entry
//    is read through the single read port, compared and shifted, then the sum is placed
//  event end adds summing of the k smallest sums, 24+clog2(MAX_LAYERS+1) divide
//    steps, a multiply and an output load; with k zero the summing and divide
//    are skipped
//  reset clears sums, counts and registers to defaults; the store needs no clear
//  a stalled result lets the next event's pads flow in; input stalls while an
//    insertion or an event end's arithmetic runs, and while its result waits to load
module truncated_mean_layer_charge import tmlc_pkg::*; #(
  parameter int unsigned MAX_LAYERS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pad transfer
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  // result transfer
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  cfg_idx_e    cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  tmlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmlc_dp #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sim/tmlc_checker.sv -----
// ---------------------------------------------------------------------------
// tmlc_checker
// predicts truncated mean results from observed pad and register transfers
// ---------------------------------------------------------------------------
// watches the pad, result and register channels of the block; every
// accepted pad updates a private copy of the layer sums, and every event end
// queues the expected result, which is compared field by field with the
// next accepted result transfer
module tmlc_checker import tmlc_pkg::*; #(
  parameter int unsigned MAX_LAYERS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_idx_e    cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] thr_q;
  logic [8:0]  frac_q;
  logic [15:0] scale_q;
  logic [23:0] layer_sum_q;
  logic [23:0] sums_q [MAX_LAYERS];
  int unsigned hits_q;
  out_t        mean_queue [$];

  assign pending_o = mean_queue.size();

  // ascending insertion, sums past a full store are dropped
  task automatic store_layer_sum(input logic [23:0] v);
    int unsigned pos;
    if (hits_q >= MAX_LAYERS) return;
    pos = hits_q;
    while (pos > 0 && sums_q[pos-1] > v) begin
      sums_q[pos] = sums_q[pos-1];
      pos--;
    end
    sums_q[pos] = v;
    hits_q++;
  endtask

  task automatic predict_pad(input in_t p);
    logic [24:0] acc;
    int unsigned frac, k;
    logic [63:0] total, avg, scaled;
    out_t r;
    if (p.pad_charge >= thr_q) begin
      acc = {1'b0, layer_sum_q} + p.pad_charge;
      layer_sum_q = acc > SumMax ? SumMax : acc[23:0];
    end
    if (p.layer_end || p.event_end) begin
      if (layer_sum_q != 0) store_layer_sum(layer_sum_q);
      layer_sum_q = '0;
    end
    if (!p.event_end) return;
    frac = frac_q > 256 ? 256 : frac_q;
    k = (frac * hits_q) >> 8;
    if (k > hits_q) k = hits_q;
    scaled = '0;
    if (k != 0) begin
      total = '0;
      for (int unsigned i = 0; i < k; i++) total += sums_q[i];
      avg = total / k;
      scaled = (avg * scale_q) >> 16;
    end
    r.mean_charge = scaled[23:0];
    r.layers_hit  = hits_q > 255 ? 8'd255 : hits_q[7:0];
    r.layers_kept = k > 255 ? 8'd255 : k[7:0];
    mean_queue.insert(mean_queue.size(), r);
    hits_q = 0;
    layer_sum_q = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      thr_q       = 16'd1;
      frac_q      = 9'd179;
      scale_q     = 16'd54613;
      layer_sum_q = '0;
      hits_q      = 0;
      mean_queue.delete();
      err_count_o = 0;
    end else begin
      // result first: a result leaving now belongs to an earlier event end
      if (out_valid_i && !out_stall_i) begin
        if (mean_queue.size() == 0) begin
          $display("%0t: unexpected result mean %0d hit %0d kept %0d", $time,
                   out_data_i.mean_charge, out_data_i.layers_hit, out_data_i.layers_kept);
          err_count_o++;
        end else begin
          want = mean_queue.pop_front();
          if (out_data_i.mean_charge !== want.mean_charge) begin
            $display("%0t: mean_charge expected %0d actual %0d", $time,
                     want.mean_charge, out_data_i.mean_charge);
            err_count_o++;
          end
          if (out_data_i.layers_hit !== want.layers_hit) begin
            $display("%0t: layers_hit expected %0d actual %0d", $time,
                     want.layers_hit, out_data_i.layers_hit);
            err_count_o++;
          end
          if (out_data_i.layers_kept !== want.layers_kept) begin
            $display("%0t: layers_kept expected %0d actual %0d", $time,
                     want.layers_kept, out_data_i.layers_kept);
            err_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_pad(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q   = cfg_data_i;
          CFG_FRACTION:  frac_q  = cfg_data_i[8:0];
          CFG_SCALE:     scale_q = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// stimulus and verdict for the truncated mean layer charge block
// ---------------------------------------------------------------------------
// directed events cover charge extremes, threshold edges, a saturating layer,
// an overfull store and an empty event; then random events run under several
// register settings with random gaps on the pad side and random result stalls
module testbench;
  import tmlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxLayers = 128;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned SettleCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_e    cfg_index = CFG_THRESHOLD;
  logic [15:0] cfg_data = '0;
  int          err_count;
  int          pending;

  // pacing knobs shared by stimulus and stall driver
  bit          steady = 1'b0;
  int unsigned thr_now = 1;
  int unsigned idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  truncated_mean_layer_charge #(.MAX_LAYERS(MaxLayers)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  tmlc_checker #(.MAX_LAYERS(MaxLayers)) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result stall: random stretches, calm while steady
  initial begin
    forever begin
      @(negedge clk_i);
      if (steady || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 30) : $urandom_range(0, 3))
          @(negedge clk_i);
      end
    end
  end

  // one pad transfer, entered and left at a falling edge
  task automatic send_pad(input logic [15:0] charge, input bit lend, input bit eend);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= '{pad_charge: charge, layer_end: lend, event_end: eend};
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // sender hold-off until every result has left the block
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_THRESHOLD) thr_now = val;
  endtask

  task automatic set_regs(input logic [15:0] thr, input logic [15:0] frac,
                          input logic [15:0] scale);
    drain();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_FRACTION, frac);
    write_reg(CFG_SCALE, scale);
  endtask

  // charges clustered on the threshold and the extremes
  function automatic logic [15:0] pick_charge();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'(thr_now);
      3: return thr_now == 0 ? 16'd0 : 16'(thr_now - 1);
      4: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // random events until about the requested number of pads has gone in
  task automatic random_events(input int unsigned pads, input bit hold_mid);
    int unsigned sent, n_layers, n_pads;
    bit lend, last, held;
    sent = 0;
    held = 0;
    while (sent < pads) begin
      steady = ($urandom_range(0, 5) == 0);
      n_layers = $urandom_range(0, 11) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int unsigned l = 0; l < n_layers; l++) begin
        n_pads = $urandom_range(1, 5);
        for (int unsigned p = 0; p < n_pads; p++) begin
          last = (l == n_layers - 1) && (p == n_pads - 1);
          lend = (p == n_pads - 1);
          // event end without layer end, and stray layer ends
          if (last && $urandom_range(0, 4) == 0) lend = 1'b0;
          if (!lend && $urandom_range(0, 15) == 0) lend = 1'b1;
          send_pad(pick_charge(), lend, last);
          sent++;
        end
      end
      if (hold_mid && !held && sent >= pads / 2) begin
        held = 1;
        if (in_valid) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
        @(negedge clk_i);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed events under reset settings
    send_pad(16'hFFFF, 1'b1, 1'b1);                 // one pad, one layer
    send_pad(16'd0, 1'b0, 1'b1);                    // empty event, nothing kept
    send_pad(16'd0, 1'b1, 1'b0);                    // below threshold
    send_pad(16'd1, 1'b1, 1'b0);                    // exactly threshold
    send_pad(16'hFFFF, 1'b0, 1'b0);
    send_pad(16'h8000, 1'b0, 1'b1);                 // event end closes the layer
    // layer sum saturating at the top of the range
    for (int i = 0; i < 260; i++) send_pad(16'hFFFF, i == 259, 1'b0);
    send_pad(16'd7, 1'b1, 1'b0);
    send_pad(16'd3, 1'b1, 1'b1);
    // more layers than the store holds
    for (int i = 0; i < MaxLayers + 12; i++)
      send_pad(16'($urandom_range(1, 65535)), 1'b1, i == MaxLayers + 11);

    random_events(40, 1'b1);
    set_regs(16'd0, 16'd256, 16'hFFFF);             // keep all, full scale
    random_events(40, 1'b0);
    set_regs(16'hFFFF, 16'd0, 16'd0);               // nothing kept
    random_events(30, 1'b0);
    set_regs(16'd200, 16'd511, 16'd32768);          // fraction above one
    random_events(40, 1'b0);
    set_regs(16'd1, 16'd1, 16'd1);
    random_events(30, 1'b0);
    set_regs(16'($urandom_range(0, 1000)), 16'($urandom_range(100, 300)),
             16'($urandom_range(0, 65535)));
    random_events(40, 1'b1);
    set_regs(16'd1, 16'd179, 16'd54613);            // back to defaults
    random_events(40, 1'b0);

    drain();
    if (err_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tmlc_pkg.sv
hdl/tmlc_ctrl.sv
hdl/tmlc_dp.sv
hdl/truncated_mean_layer_charge.sv
sim/tmlc_checker.sv
sim/testbench.sv
